/* rtl/core/tsdz_pkg.sv */
// ----------------------------------------------------------------------------
// tsdz_pkg
// Shared types, constants and the Q1.15 output saturation for the radial
// dead-zone stick block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsdz_pkg;

   localparam int Q_W    = 16;
   localparam int Q_FRAC = 15;

   typedef logic [Q_W-1:0] q15_type;

   localparam q15_type Q_POS_MAX = 16'h7fff;
   localparam q15_type Q_NEG_MAX = 16'h8000;

   // sign and magnitude to signed q1.15, clipped at both ends
   function automatic q15_type to_q15(input logic neg, input q15_type mag);
      q15_type res;
      if (neg) begin
         res = (mag > Q_NEG_MAX) ? Q_NEG_MAX : q15_type'(16'h0000 - mag);
      end else begin
         res = (mag > Q_POS_MAX) ? Q_POS_MAX : mag;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/tsdz_sqrt.sv */
// ----------------------------------------------------------------------------
// tsdz_sqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// bus that travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdz_sqrt #(
   parameter int W      = 16,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2*W-1:0]    in_sq,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [W-1:0]           out_root,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int RW = 2*W + 1;

   logic              valid_ff [W];
   logic [RW-1:0]     rem_ff   [W];
   logic [W-1:0]      root_ff  [W];
   logic [SIDE_W-1:0] side_ff  [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      localparam int J = W - 1 - k;
      logic              valid_src;
      logic [RW-1:0]     rem_src;
      logic [W-1:0]      root_src;
      logic [SIDE_W-1:0] side_src;
      logic [RW-1:0]     trial;
      logic              take;
      logic [RW-1:0]     rem_in;
      logic [W-1:0]      root_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = RW'(in_sq);
         assign root_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      // (2r + 2^j) * 2^j against the remainder
      assign trial   = (RW'(root_src) << (J + 1)) | (RW'(1) << (2 * J));
      assign take    = rem_src >= trial;
      assign rem_in  = take ? (rem_src - trial) : rem_src;
      assign root_in = take ? (root_src | (W'(1) << J)) : root_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign out_root  = root_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

`default_nettype wire

/* rtl/core/tsdz_div.sv */
// ----------------------------------------------------------------------------
// tsdz_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in Q_W bits, so only those bits are resolved.
// ----------------------------------------------------------------------------
`default_nettype none

module tsdz_div #(
   parameter int NW     = 32,
   parameter int DW     = 16,
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NW-1:0]     in_num,
   input  wire logic [DW-1:0]     in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output tsdz_pkg::q15_type      out_quot,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int QW = tsdz_pkg::Q_W;
   localparam int CW = (NW > DW + QW) ? NW : DW + QW;

   logic              valid_ff [QW];
   logic [CW-1:0]     rem_ff   [QW];
   logic [DW-1:0]     den_ff   [QW];
   logic [QW-1:0]     quot_ff  [QW];
   logic [SIDE_W-1:0] side_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int SH = QW - 1 - k;
      logic              valid_src;
      logic [CW-1:0]     rem_src;
      logic [DW-1:0]     den_src;
      logic [QW-1:0]     quot_src;
      logic [SIDE_W-1:0] side_src;
      logic [CW-1:0]     trial;
      logic              take;
      logic [CW-1:0]     rem_in;
      logic [QW-1:0]     quot_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = CW'(in_num);
         assign den_src   = in_den;
         assign quot_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign quot_src  = quot_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      assign trial   = CW'(den_src) << SH;
      assign take    = rem_src >= trial;
      assign rem_in  = take ? (rem_src - trial) : rem_src;
      assign quot_in = quot_src | (QW'(take) << SH);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_src;
            quot_ff[k] <= quot_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire

/* rtl/core/thumbstick_radial_deadzone.sv */
// ----------------------------------------------------------------------------
// thumbstick_radial_deadzone
// Radial dead zone and rescaling of one thumbstick sample to signed Q1.15.
//
// Input channel req_*: x, y sample and dead-zone radius, valid/stall.
// Result channel rsp_*: scaled x, y and a dead-zone flag, valid/stall.
// One result per item, in order. Items enter every cycle while the result
// side keeps up, so throughput is one item per clock.
// The pipeline has three stages for magnitude, squares and compare, one per
// root bit in the square root, sixteen for the magnitude scale divider,
// sixteen for the parallel component dividers, plus three glue and output
// registers.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps filling until its last stage is occupied; only then is
// req_stall raised. Synchronous reset drops every item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module thumbstick_radial_deadzone #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_x_value,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_y_value,
   input  wire logic [SAMPLE_WIDTH-2:0]   req_deadzone,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [15:0]             rsp_out_x,
   output logic signed [15:0]             rsp_out_y,
   output logic                           rsp_in_deadzone
);

   localparam int W     = SAMPLE_WIDTH;
   localparam int QW    = tsdz_pkg::Q_W;
   localparam int FR    = tsdz_pkg::Q_FRAC;
   localparam logic [W-2:0] FULL = '1;
   localparam int SQ_SIDE = 3*W + 2;
   localparam int D1_SIDE = 3*W + 3;
   localparam int PW      = W + QW;

   logic en;
   logic last_valid;
   logic out_free;

   // stage 1: sign and magnitude
   logic         v1_ff;
   logic [W-1:0] ax1_ff, ay1_ff;
   logic         nx1_ff, ny1_ff;
   logic [W-2:0] dz1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff <= req_x_value[W-1] ? (~req_x_value + W'(1)) : req_x_value;
         ay1_ff <= req_y_value[W-1] ? (~req_y_value + W'(1)) : req_y_value;
         nx1_ff <= req_x_value[W-1];
         ny1_ff <= req_y_value[W-1];
         dz1_ff <= req_deadzone;
      end
   end

   // stage 2: squares
   logic           v2_ff;
   logic [2*W-1:0] sqx2_ff, sqy2_ff;
   logic [2*W-1:0] dzsq2_ff;
   logic           dzfull2_ff;
   logic [W-1:0]   ax2_ff, ay2_ff;
   logic           nx2_ff, ny2_ff;
   logic [W-2:0]   dz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx2_ff    <= (2*W)'(ax1_ff) * (2*W)'(ax1_ff);
         sqy2_ff    <= (2*W)'(ay1_ff) * (2*W)'(ay1_ff);
         dzsq2_ff   <= (2*W)'(dz1_ff) * (2*W)'(dz1_ff);
         dzfull2_ff <= dz1_ff == FULL;
         ax2_ff     <= ax1_ff;
         ay2_ff     <= ay1_ff;
         nx2_ff     <= nx1_ff;
         ny2_ff     <= ny1_ff;
         dz2_ff     <= dz1_ff;
      end
   end

   // stage 3: squared length and dead-zone test
   logic           v3_ff;
   logic [2*W-1:0] s3_ff;
   logic [SQ_SIDE-1:0] side3_ff;
   logic [2*W-1:0] s3_in;

   assign s3_in = sqx2_ff + sqy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff    <= s3_in;
         side3_ff <= {ax2_ff, ay2_ff, nx2_ff, ny2_ff, dz2_ff,
                      dzfull2_ff || (s3_in <= dzsq2_ff)};
      end
   end

   // square root
   logic               sq_valid;
   logic [W-1:0]       sq_root;
   logic [SQ_SIDE-1:0] sq_side;

   tsdz_sqrt #(
      .W      (W),
      .SIDE_W (SQ_SIDE)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_sq     (s3_ff),
      .in_side   (side3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   logic [W-1:0] ax_s, ay_s;
   logic         nx_s, ny_s, dead_s;
   logic [W-2:0] dz_s;
   logic [W-2:0] clip_s;

   assign {ax_s, ay_s, nx_s, ny_s, dz_s, dead_s} = sq_side;
   assign clip_s = (sq_root < W'(FULL)) ? sq_root[W-2:0] : FULL;

   // stage 4: clipped length minus radius, remaining range
   logic         v4_ff;
   logic [W-2:0] num4_ff, den4_ff;
   logic [D1_SIDE-1:0] side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num4_ff  <= (clip_s > dz_s) ? (clip_s - dz_s) : '0;
         den4_ff  <= FULL - dz_s;
         side4_ff <= {ax_s, ay_s, nx_s, ny_s, sq_root, dead_s};
      end
   end

   // magnitude scale q = (num << 15) / range
   logic               d1_valid;
   tsdz_pkg::q15_type  d1_quot;
   logic [D1_SIDE-1:0] d1_side;

   tsdz_div #(
      .NW     (W - 1 + FR),
      .DW     (W - 1),
      .SIDE_W (D1_SIDE)
   ) u_div_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    ({num4_ff, FR'(0)}),
      .in_den    (den4_ff),
      .in_side   (side4_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   logic [W-1:0] ax_d, ay_d, len_d;
   logic         nx_d, ny_d, dead_d;

   assign {ax_d, ay_d, nx_d, ny_d, len_d, dead_d} = d1_side;

   // stage 5: component times scale
   logic         v5_ff;
   logic [PW-1:0] px5_ff, py5_ff;
   logic [W-1:0] len5_ff;
   logic         nx5_ff, ny5_ff, dead5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px5_ff   <= PW'(ax_d) * PW'(d1_quot);
         py5_ff   <= PW'(ay_d) * PW'(d1_quot);
         len5_ff  <= len_d;
         nx5_ff   <= nx_d;
         ny5_ff   <= ny_d;
         dead5_ff <= dead_d;
      end
   end

   // component / length, both in parallel
   logic              dx_valid, dy_valid;
   tsdz_pkg::q15_type dx_quot, dy_quot;
   logic [1:0]        dx_side;
   logic              dy_side;

   tsdz_div #(
      .NW     (PW),
      .DW     (W),
      .SIDE_W (2)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_num    (px5_ff),
      .in_den    (len5_ff),
      .in_side   ({nx5_ff, dead5_ff}),
      .out_valid (dx_valid),
      .out_quot  (dx_quot),
      .out_side  (dx_side)
   );

   tsdz_div #(
      .NW     (PW),
      .DW     (W),
      .SIDE_W (1)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_num    (py5_ff),
      .in_den    (len5_ff),
      .in_side   (ny5_ff),
      .out_valid (dy_valid),
      .out_quot  (dy_quot),
      .out_side  (dy_side)
   );

   // pipeline moves unless a finished item is blocked behind a held result
   assign last_valid = dx_valid && dy_valid;
   assign out_free   = !rsp_valid || !rsp_stall;
   assign en         = !last_valid || out_free;
   assign req_stall  = !en;

   // output register
   logic                 rsp_valid_ff;
   tsdz_pkg::q15_type    out_x_ff, out_y_ff;
   logic                 dead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && last_valid) begin
         dead_ff  <= dx_side[0];
         out_x_ff <= dx_side[0] ? '0 : tsdz_pkg::to_q15(dx_side[1], dx_quot);
         out_y_ff <= dx_side[0] ? '0 : tsdz_pkg::to_q15(dy_side, dy_quot);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_in_deadzone = dead_ff;

   a_dead_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_deadzone |-> rsp_out_x == 16'sd0 && rsp_out_y == 16'sd0)
      else $error("dead-zone item with nonzero output");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   a_lanes_align : assert property (@(posedge clock) disable iff (reset)
      dx_valid == dy_valid)
      else $error("component dividers out of step");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
